### rtl/rit_pkg.sv
// package for the integer to radix text block
// holds payload structs, divider handshake structs, constants and the glyph map
// no dependencies
package rit_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(VALUE_WIDTH);
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 7;

  localparam logic [DIGIT_W-1:0] MIN_BASE   = 6'd2;
  localparam logic [DIGIT_W-1:0] MAX_BASE   = 6'd36;
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A     = 7'h41;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'h2D;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value_bits;
    logic                   signed_mode;
    logic [5:0]             radix;
  } num_t;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
  } chr_t;

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [DIGIT_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [DIGIT_W-1:0]     remainder;
  } div_rsp_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + {1'b0, d};
    end else begin
      c = CHAR_A + {1'b0, d - DEC_DIGITS};
    end
    return c;
  endfunction

endpackage

### rtl/rit_div.sv
// restoring divider, one quotient bit per cycle, small divisor
// divides a VALUE_WIDTH dividend by a 6-bit divisor in VALUE_WIDTH steps
// depends on rit_pkg
module rit_div
  import rit_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                   busy;
  logic                   done;
  logic [IDX_W-1:0]       cnt;
  logic [VALUE_WIDTH-1:0] quot;
  logic [DIGIT_W-1:0]     rem;
  logic [DIGIT_W-1:0]     dsr;

  logic [DIGIT_W:0]       shifted;
  logic [DIGIT_W:0]       diff;
  logic                   ge;

  // remainder stays below the divisor, so the shifted value fits in 7 bits
  assign shifted = {rem, quot[VALUE_WIDTH-1]};
  assign ge      = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        quot <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
      end else if (busy) begin
        quot <= {quot[VALUE_WIDTH-2:0], ge};
        rem  <= ge ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
        cnt  <= cnt + 1'b1;
        if (cnt == IDX_W'(VALUE_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quot;
  assign rsp.remainder = rem;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < dsr))
    else $error("remainder not below divisor");

endmodule

### rtl/integer_to_radix_text_top.sv
// integer to radix text converter, top level with sequencer and output register
// instantiates rit_div; depends on rit_pkg
//
// channel | dir | handshake            | payload
// num     | in  | num_valid/num_ready  | value_bits, signed_mode, radix
// chr     | out | chr_valid/chr_ready  | text_char, last_char
//
// each digit is one pass of the bit-serial divider; after the last digit is stored,
// the first character is offered from the output register,
// then one character per cycle while chr_ready is high
// digits are held in a 32-entry register store and read back in reverse
// reset is synchronous and clears the sequencer, divider and output valid
// num_ready is high only between numbers; a stalled output holds its character
module integer_to_radix_text_top
  import rit_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic num_valid,
  output logic num_ready,
  input  num_t num,
  output logic chr_valid,
  input  logic chr_ready,
  output chr_t chr
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT} state_t;

  state_t             state;
  logic [DIGIT_W-1:0] base;
  logic               minus;
  logic [CNT_W-1:0]   digit_count;
  logic [DIGIT_W-1:0] digit_store [VALUE_WIDTH];

  div_req_t               req;
  div_rsp_t               rsp;
  logic                   accept;
  logic [DIGIT_W-1:0]     base_next;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;
  logic [CNT_W-1:0]       count_inc;
  logic                   split_end;
  logic                   out_free;
  logic [CNT_W-1:0]       rd_ptr;

  assign num_ready = (state == S_IDLE);
  assign accept    = num_valid && num_ready;
  assign out_free  = !chr_valid || chr_ready;

  always_comb begin
    priority if (num.radix < MIN_BASE) begin
      base_next = MIN_BASE;
    end else if (num.radix > MAX_BASE) begin
      base_next = MAX_BASE;
    end else begin
      base_next = num.radix;
    end
  end

  assign neg = num.signed_mode && num.value_bits[VALUE_WIDTH-1];
  assign mag = neg ? (~num.value_bits + 1'b1) : num.value_bits;

  assign count_inc = digit_count + 1'b1;
  assign split_end = (rsp.quotient == '0) || (count_inc == CNT_W'(VALUE_WIDTH));
  assign rd_ptr    = digit_count - 1'b1;

  assign req.start    = accept || (state == S_DIV && rsp.done && !split_end);
  assign req.dividend = accept ? mag : rsp.quotient;
  assign req.divisor  = accept ? base_next : base;

  rit_div u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      minus       <= 1'b0;
      digit_count <= '0;
      chr_valid   <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) begin
        chr_valid <= 1'b1;
      end else if (chr_ready) begin
        chr_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            base        <= base_next;
            minus       <= neg;
            digit_count <= '0;
            state       <= S_DIV;
          end
        end
        S_DIV: begin
          if (rsp.done) begin
            digit_store[digit_count[IDX_W-1:0]] <= rsp.remainder;
            digit_count <= count_inc;
            if (split_end) begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (minus) begin
              chr.text_char <= CHAR_MINUS;
              chr.last_char <= 1'b0;
              minus         <= 1'b0;
            end else begin
              // most significant digit sits at the top of the store
              chr.text_char <= glyph(digit_store[rd_ptr[IDX_W-1:0]]);
              chr.last_char <= (digit_count == CNT_W'(1));
              digit_count   <= rd_ptr;
              if (digit_count == CNT_W'(1)) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_emit_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (minus || digit_count != '0))
    else $error("emit state with nothing to send");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CNT_W'(VALUE_WIDTH))
    else $error("digit count beyond store depth");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_DIV))
    else $error("divider finished outside the split phase");

  a_last_ends_number: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free && !minus && digit_count == CNT_W'(1)) |=>
      (state == S_IDLE && chr_valid && chr.last_char))
    else $error("final character not marked");

endmodule

### tb/tb.sv
// self-checking testbench for integer_to_radix_text_top
// predicts the character stream of every accepted number and compares each character transfer
// depends on rit_pkg and the rtl of integer_to_radix_text_top
module tb
  import rit_pkg::*;
();

  localparam int RANDOM_PER_PHASE = 35;
  localparam int LONG_HOLD        = 1500;
  localparam int TAIL_CYCLES      = 1200;
  localparam int QUIET_LIMIT      = 20000;

  // expected character stream, built per number, checked per character transfer
  class radix_text_checker;
    chr_t pending_chars[$];
    int   numbers_seen;
    int   chars_checked;
    int   errors;

    function new();
      numbers_seen  = 0;
      chars_checked = 0;
      errors        = 0;
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    function logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DEC_DIGITS) begin
        c = CHAR_ZERO + CHAR_W'(d);
      end else begin
        c = CHAR_A + CHAR_W'(d - DEC_DIGITS);
      end
      return c;
    endfunction

    function void note_number(input num_t n);
      logic [VALUE_WIDTH-1:0] mag;
      logic [DIGIT_W-1:0]     base;
      logic [DIGIT_W-1:0]     digits[$];
      logic                   neg;
      chr_t                   c;
      int                     i;
      base = n.radix;
      if (base < MIN_BASE) begin
        base = MIN_BASE;
      end else if (base > MAX_BASE) begin
        base = MAX_BASE;
      end
      neg = n.signed_mode && n.value_bits[VALUE_WIDTH-1];
      mag = neg ? (VALUE_WIDTH'(0) - n.value_bits) : n.value_bits;
      // least significant digit first, zero still gives one digit
      do begin
        digits.push_back(DIGIT_W'(mag % VALUE_WIDTH'(base)));
        mag = mag / VALUE_WIDTH'(base);
      end while (mag != 0);
      if (neg) begin
        c.text_char = CHAR_MINUS;
        c.last_char = 1'b0;
        pending_chars.push_back(c);
      end
      for (i = digits.size() - 1; i >= 0; i--) begin
        c.text_char = digit_char(digits[i]);
        c.last_char = (i == 0);
        pending_chars.push_back(c);
      end
      numbers_seen++;
    endfunction

    function void check_char(input chr_t got);
      chr_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected character 0x%02h, last_char %0b", got.text_char, got.last_char);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (got.text_char !== want.text_char) begin
          $error("text_char: expected 0x%02h, got 0x%02h", want.text_char, got.text_char);
          errors++;
        end
        if (got.last_char !== want.last_char) begin
          $error("last_char: expected %0b, got %0b", want.last_char, got.last_char);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic num_valid = 1'b0;
  logic num_ready;
  num_t num       = '0;
  logic chr_valid;
  logic chr_ready = 1'b0;
  chr_t chr;

  radix_text_checker text_sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 1'b0;
  int quiet_cycles   = 0;

  always #5 clk = ~clk;

  integer_to_radix_text_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .num_valid(num_valid),
    .num_ready(num_ready),
    .num      (num),
    .chr_valid(chr_valid),
    .chr_ready(chr_ready),
    .chr      (chr)
  );

  // note inputs and check outputs on every transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (num_valid && num_ready) begin
        text_sb.note_number(num);
      end
      if (chr_valid && chr_ready) begin
        text_sb.check_char(chr);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (num_valid && num_ready) || (chr_valid && chr_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", quiet_cycles);
        $display("integer_to_radix_text_top verification failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold counted here
  initial begin : receiver
    int i;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        chr_ready <= 1'b0;
        for (i = 0; i < LONG_HOLD; i++) begin
          @(posedge clk);
        end
      end else begin
        chr_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic num_t make_num(input logic [VALUE_WIDTH-1:0] v, input logic s,
                                    input logic [5:0] r);
    num_t n;
    n.value_bits  = v;
    n.signed_mode = s;
    n.radix       = r;
    return n;
  endfunction

  function automatic num_t random_number();
    num_t n;
    int   kind;
    kind          = $urandom_range(9);
    n.signed_mode = 1'($urandom_range(1));
    n.radix       = 6'($urandom_range(63));
    case (kind)
      4, 5: n.value_bits = $urandom_range(2000);
      6:    n.value_bits = VALUE_WIDTH'(0) - VALUE_WIDTH'($urandom_range(2000, 1));
      7: begin
        case ($urandom_range(4))
          0:       n.value_bits = '0;
          1:       n.value_bits = 32'd1;
          2:       n.value_bits = 32'h7FFF_FFFF;
          3:       n.value_bits = 32'h8000_0000;
          default: n.value_bits = 32'hFFFF_FFFF;
        endcase
      end
      8:       n.value_bits = $urandom >> $urandom_range(31);
      default: n.value_bits = $urandom;
    endcase
    return n;
  endfunction

  // valid stays high across back-to-back transfers
  task automatic send_number(input num_t n);
    if ($urandom_range(99) < send_idle_pct) begin
      num_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) begin
        @(posedge clk);
      end
    end
    num_valid <= 1'b1;
    num       <= n;
    do begin
      @(posedge clk);
    end while (!num_ready);
  endtask

  task automatic drain_text();
    num_valid <= 1'b0;
    @(posedge clk);
    while (text_sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int ph;
    int k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      if (ph == 0) begin
        send_number(make_num(32'd0, 1'b0, 6'd10));
        send_number(make_num(32'd0, 1'b1, 6'd2));
        send_number(make_num(32'hFFFF_FFFF, 1'b0, 6'd2));
        send_number(make_num(32'hFFFF_FFFF, 1'b1, 6'd2));
        send_number(make_num(32'h8000_0000, 1'b1, 6'd2));
        send_number(make_num(32'h8000_0000, 1'b0, 6'd16));
        send_number(make_num(32'h7FFF_FFFF, 1'b1, 6'd10));
        send_number(make_num(32'hFFFF_FFFF, 1'b0, 6'd36));
        send_number(make_num(32'd35, 1'b0, 6'd36));
        send_number(make_num(32'd36, 1'b0, 6'd36));
        send_number(make_num(32'd9, 1'b0, 6'd10));
        send_number(make_num(32'd10, 1'b1, 6'd16));
        // out of range bases clamp to 2 and 36
        send_number(make_num(32'd5, 1'b0, 6'd0));
        send_number(make_num(32'd6, 1'b1, 6'd1));
        send_number(make_num(32'd35, 1'b0, 6'd37));
        send_number(make_num(32'hDEAD_BEEF, 1'b1, 6'd63));
        send_number(make_num(32'd123456789, 1'b1, 6'd7));
        send_number(make_num(32'h8000_0000, 1'b1, 6'd0));
        send_number(make_num(32'hFFFF_FFFF, 1'b1, 6'd63));
        send_number(make_num(32'hAAAA_AAAA, 1'b0, 6'd3));
        send_number(make_num(32'h5555_5555, 1'b1, 6'd5));
        send_number(make_num(32'd1, 1'b0, 6'd36));
        drain_text();
        // output held off while numbers keep coming, so the input backs up
        hold_request = 1'b1;
      end
      for (k = 0; k < RANDOM_PER_PHASE; k++) begin
        send_number(random_number());
      end
      drain_text();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (text_sb.pending() != 0) begin
      $error("%0d expected characters never arrived", text_sb.pending());
      text_sb.errors++;
    end
    $display("converted %0d numbers into %0d checked characters, bases 0..63 with clamping,",
             text_sb.numbers_seen, text_sb.chars_checked);
    $display("signed and unsigned extremes, four flow-control phases and one long output hold");
    if (text_sb.errors == 0) begin
      $display("integer_to_radix_text_top verification clean");
    end else begin
      $display("integer_to_radix_text_top verification failed");
    end
    $finish;
  end

endmodule
